@@ hdl/ycrgb_pkg.sv @@
// Shared constants and types for the YCbCr to RGB pixel converter.
// Used by the pipelined divider and by the top level; no dependencies.
package ycrgb_pkg;

	// Sample and result widths.
	localparam int SAMPLE_W   = 10;
	localparam int OUT_W      = 8;
	localparam int OUT_SHIFT  = SAMPLE_W - OUT_W;
	localparam int FULL_SCALE = (1 << SAMPLE_W) - 1;
	localparam int CHROMA_MID = 1 << (SAMPLE_W - 1);

	// Register field widths.
	localparam int RANGE_W  = 10;
	localparam int COEFF_W  = 11;
	localparam int GCOEFF_W = 12;
	localparam int CFG_W    = GCOEFF_W;
	localparam int CFG_IDX_W = 3;
	localparam int COEFF_ONE = 1024;
	localparam int COEFF_SHIFT = 10;

	// Rescale arithmetic: magnitude of an offset sample, and the dividend
	// after multiplication by full scale.
	localparam int MAG_W      = SAMPLE_W;
	localparam int DIVIDEND_W = MAG_W + SAMPLE_W;
	localparam int DIV_STAGES = DIVIDEND_W;
	localparam int QUOT_W     = DIVIDEND_W + 1;

	// Mixing arithmetic.
	localparam int KFAC_W = COEFF_W + 2;
	localparam int PROD_W = KFAC_W + QUOT_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int TRQ_W  = SUM_W - COEFF_SHIFT;
	localparam int MIX_W  = TRQ_W + 1;

	// Side information that travels with each pixel through the pipeline.
	typedef struct packed {
		logic             ycbcr;
		logic [OUT_W-1:0] r;
		logic [OUT_W-1:0] g;
		logic [OUT_W-1:0] b;
	} pix_tag_t;

endpackage

@@ hdl/ycrgb_div_pipe.sv @@
// Pipelined restoring divider for the three rescale lanes (luma, Cb, Cr).
// One quotient bit per stage; depends on ycrgb_pkg.
module ycrgb_div_pipe (
	input  logic                                      clk,
	input  logic [ycrgb_pkg::DIV_STAGES-1:0]          en,
	input  logic [ycrgb_pkg::RANGE_W-1:0]             luma_div,
	input  logic [ycrgb_pkg::RANGE_W-1:0]             chroma_div,
	input  logic [2:0][ycrgb_pkg::DIVIDEND_W-1:0]     num,
	input  logic [2:0]                                neg,
	input  ycrgb_pkg::pix_tag_t                       tag,
	output logic [2:0][ycrgb_pkg::DIVIDEND_W-1:0]     quot,
	output logic [2:0]                                quot_neg,
	output ycrgb_pkg::pix_tag_t                       quot_tag
);

	localparam int RW = ycrgb_pkg::RANGE_W;
	localparam int NW = ycrgb_pkg::DIVIDEND_W;
	localparam int NS = ycrgb_pkg::DIV_STAGES;

	// Stage registers: partial remainder, shifting dividend/quotient word, sign, tag.
	logic [2:0][RW-1:0]   rem_s [NS-1];
	logic [2:0][NW-1:0]   num_s [NS];
	logic [2:0]           neg_s [NS];
	ycrgb_pkg::pix_tag_t  tag_s [NS];

	// A zero range divides as a range of one.
	logic [2:0][RW-1:0] dvs;
	assign dvs[0] = (luma_div == '0) ? RW'(1) : luma_div;
	assign dvs[1] = (chroma_div == '0) ? RW'(1) : chroma_div;
	assign dvs[2] = dvs[1];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [2:0][RW-1:0] rem_in;
		logic [2:0][NW-1:0] num_in;
		logic [2:0]         neg_in;
		ycrgb_pkg::pix_tag_t tag_in;
		logic [2:0][RW-1:0] rem_nx;
		logic [2:0][NW-1:0] num_nx;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign neg_in = neg;
			assign tag_in = tag;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign neg_in = neg_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		// Bring down the next dividend bit and subtract the divisor if it fits.
		always_comb begin
			logic [RW:0] trial;
			logic        qbit;
			for (int l = 0; l < 3; l++) begin
				trial = {rem_in[l], num_in[l][NW-1]};
				qbit  = (trial >= {1'b0, dvs[l]});
				if (qbit) begin
					trial = trial - {1'b0, dvs[l]};
				end
				rem_nx[l] = trial[RW-1:0];
				num_nx[l] = {num_in[l][NW-2:0], qbit};
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				num_s[k] <= num_nx;
				neg_s[k] <= neg_in;
				tag_s[k] <= tag_in;
			end
		end

		if (k < NS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= rem_nx;
				end
			end
		end
	end

	assign quot     = num_s[NS-1];
	assign quot_neg = neg_s[NS-1];
	assign quot_tag = tag_s[NS-1];

endmodule

@@ hdl/ycbcr_to_rgb_pixel_converter_top.sv @@
// Top level of the YCbCr to RGB pixel converter: configuration registers and pipeline.
// Depends on ycrgb_pkg and ycrgb_div_pipe.
//
// The converter takes one pixel request per clock while pix_ready is high and returns
// one 8-bit RGB result per pixel, in order. Every pixel passes through 27 register
// stages; 20 of those stages are the restoring divider that rescales luma and chroma
// by full scale over their ranges, one quotient bit per stage. Each stage advances on
// its own, so a stalled output only holds back the stages that are full, and requests
// keep being taken while bubbles remain. Configuration registers are written through
// cfg_we, cfg_index and cfg_data and must only change while no pixel is in flight.
module ycbcr_to_rgb_pixel_converter_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port
	input  logic                                  cfg_we,
	input  logic [ycrgb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ycrgb_pkg::CFG_W-1:0]           cfg_data,
	// Pixel requests
	input  logic                                  pix_valid,
	output logic                                  pix_ready,
	input  logic [ycrgb_pkg::SAMPLE_W-1:0]        sample_a,
	input  logic [ycrgb_pkg::SAMPLE_W-1:0]        sample_b,
	input  logic [ycrgb_pkg::SAMPLE_W-1:0]        sample_c,
	// RGB results
	output logic                                  rgb_valid,
	input  logic                                  rgb_ready,
	output logic [ycrgb_pkg::OUT_W-1:0]           red_out,
	output logic [ycrgb_pkg::OUT_W-1:0]           green_out,
	output logic [ycrgb_pkg::OUT_W-1:0]           blue_out
);

	localparam int SW  = ycrgb_pkg::SAMPLE_W;
	localparam int OW  = ycrgb_pkg::OUT_W;
	localparam int MW  = ycrgb_pkg::MAG_W;
	localparam int NW  = ycrgb_pkg::DIVIDEND_W;
	localparam int QW  = ycrgb_pkg::QUOT_W;
	localparam int KW  = ycrgb_pkg::KFAC_W;
	localparam int PW  = ycrgb_pkg::PROD_W;
	localparam int UW  = ycrgb_pkg::SUM_W;
	localparam int TW  = ycrgb_pkg::TRQ_W;
	localparam int XW  = ycrgb_pkg::MIX_W;
	localparam int CSH = ycrgb_pkg::COEFF_SHIFT;

	// Register indexes.
	localparam logic [ycrgb_pkg::CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [ycrgb_pkg::CFG_IDX_W-1:0] REG_LUMA_OFS = 3'd1;
	localparam logic [ycrgb_pkg::CFG_IDX_W-1:0] REG_LUMA_RNG = 3'd2;
	localparam logic [ycrgb_pkg::CFG_IDX_W-1:0] REG_CHR_RNG  = 3'd3;
	localparam logic [ycrgb_pkg::CFG_IDX_W-1:0] REG_RED_K    = 3'd4;
	localparam logic [ycrgb_pkg::CFG_IDX_W-1:0] REG_BLUE_K   = 3'd5;
	localparam logic [ycrgb_pkg::CFG_IDX_W-1:0] REG_G_CB     = 3'd6;
	localparam logic [ycrgb_pkg::CFG_IDX_W-1:0] REG_G_CR     = 3'd7;

	// Stage positions along the pipeline.
	localparam int ST_DIV = 2;
	localparam int ST_Q   = ST_DIV + ycrgb_pkg::DIV_STAGES;
	localparam int ST_M1  = ST_Q + 1;
	localparam int ST_M2  = ST_Q + 2;
	localparam int ST_M3  = ST_Q + 3;
	localparam int ST_OUT = ST_Q + 4;
	localparam int N_ST   = ST_OUT + 1;

	// Truncating division by 1024: bias negative values before the shift.
	function automatic logic signed [TW-1:0] trunc_div(input logic signed [UW-1:0] v);
		logic signed [UW-1:0] biased;
		biased = v + (v[UW-1] ? UW'(ycrgb_pkg::COEFF_ONE - 1) : UW'(0));
		return biased[UW-1:CSH];
	endfunction

	// Clamp to [0, full scale - 1] and keep the top eight bits.
	function automatic logic [OW-1:0] clamp_shift(input logic signed [XW-1:0] v);
		logic [SW-1:0] c;
		if (v < 0) begin
			c = '0;
		end else if (v >= XW'(ycrgb_pkg::FULL_SCALE)) begin
			c = SW'(ycrgb_pkg::FULL_SCALE - 1);
		end else begin
			c = v[SW-1:0];
		end
		return c[SW-1 -: OW];
	endfunction

	// ---------------------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------------------
	logic                              ycbcr_mode_q;
	logic [ycrgb_pkg::RANGE_W-1:0]     luma_offset_q;
	logic [ycrgb_pkg::RANGE_W-1:0]     luma_range_q;
	logic [ycrgb_pkg::RANGE_W-1:0]     chroma_range_q;
	logic [ycrgb_pkg::COEFF_W-1:0]     red_coeff_q;
	logic [ycrgb_pkg::COEFF_W-1:0]     blue_coeff_q;
	logic [ycrgb_pkg::GCOEFF_W-1:0]    green_from_cb_q;
	logic [ycrgb_pkg::GCOEFF_W-1:0]    green_from_cr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ycbcr_mode_q    <= 1'b1;
			luma_offset_q   <= 10'd64;
			luma_range_q    <= 10'd876;
			chroma_range_q  <= 10'd896;
			red_coeff_q     <= 11'd218;
			blue_coeff_q    <= 11'd74;
			green_from_cb_q <= 12'd191;
			green_from_cr_q <= 12'd479;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:     ycbcr_mode_q    <= cfg_data[0];
				REG_LUMA_OFS: luma_offset_q   <= cfg_data[ycrgb_pkg::RANGE_W-1:0];
				REG_LUMA_RNG: luma_range_q    <= cfg_data[ycrgb_pkg::RANGE_W-1:0];
				REG_CHR_RNG:  chroma_range_q  <= cfg_data[ycrgb_pkg::RANGE_W-1:0];
				REG_RED_K:    red_coeff_q     <= cfg_data[ycrgb_pkg::COEFF_W-1:0];
				REG_BLUE_K:   blue_coeff_q    <= cfg_data[ycrgb_pkg::COEFF_W-1:0];
				REG_G_CB:     green_from_cb_q <= cfg_data;
				REG_G_CR:     green_from_cr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage valid bits and per-stage advance
	// ---------------------------------------------------------------------------------
	logic [N_ST-1:0] vld_q;
	logic [N_ST:0]   en;

	// A stage may load when it is empty or when the stage after it moves on.
	assign en[N_ST] = rgb_ready;
	for (genvar k = 0; k < N_ST; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= pix_valid;
			end
			for (int k = 1; k < N_ST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign pix_ready = en[0];
	assign rgb_valid = vld_q[N_ST-1];

	// ---------------------------------------------------------------------------------
	// Stage 1: remove the offsets, split into sign and magnitude
	// ---------------------------------------------------------------------------------
	logic [2:0][MW-1:0]     mag_s1;
	logic [2:0]             neg_s1;
	ycrgb_pkg::pix_tag_t    tag_s1;
	logic [2:0][SW:0]       diff;
	logic [2:0][SW:0]       diff_abs;

	assign diff[0] = {1'b0, sample_a} - {1'b0, luma_offset_q};
	assign diff[1] = {1'b0, sample_b} - (SW+1)'(ycrgb_pkg::CHROMA_MID);
	assign diff[2] = {1'b0, sample_c} - (SW+1)'(ycrgb_pkg::CHROMA_MID);

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			diff_abs[l] = diff[l][SW] ? -diff[l] : diff[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int l = 0; l < 3; l++) begin
				mag_s1[l] <= diff_abs[l][MW-1:0];
				neg_s1[l] <= diff[l][SW];
			end
			tag_s1.ycbcr <= ycbcr_mode_q;
			tag_s1.r     <= sample_a[SW-1 -: OW];
			tag_s1.g     <= sample_b[SW-1 -: OW];
			tag_s1.b     <= sample_c[SW-1 -: OW];
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 2: multiply the magnitudes by full scale (2^n - 1, a shift and subtract)
	// ---------------------------------------------------------------------------------
	logic [2:0][NW-1:0]     num_s2;
	logic [2:0]             neg_s2;
	ycrgb_pkg::pix_tag_t    tag_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int l = 0; l < 3; l++) begin
				num_s2[l] <= {mag_s1[l], SW'(0)} - NW'(mag_s1[l]);
			end
			neg_s2 <= neg_s1;
			tag_s2 <= tag_s1;
		end
	end

	// ---------------------------------------------------------------------------------
	// Divider stages: rescale by range
	// ---------------------------------------------------------------------------------
	logic [2:0][NW-1:0]     quot;
	logic [2:0]             quot_neg;
	ycrgb_pkg::pix_tag_t    quot_tag;

	ycrgb_div_pipe u_div (
		.clk        (clk),
		.en         (en[ST_DIV +: ycrgb_pkg::DIV_STAGES]),
		.luma_div   (luma_range_q),
		.chroma_div (chroma_range_q),
		.num        (num_s2),
		.neg        (neg_s2),
		.tag        (tag_s2),
		.quot       (quot),
		.quot_neg   (quot_neg),
		.quot_tag   (quot_tag)
	);

	// ---------------------------------------------------------------------------------
	// Stage 3: restore the sign of the rescaled values
	// ---------------------------------------------------------------------------------
	logic signed [2:0][QW-1:0] yc_s3;
	ycrgb_pkg::pix_tag_t       tag_s3;

	always_ff @(posedge clk) begin
		if (en[ST_Q]) begin
			for (int l = 0; l < 3; l++) begin
				yc_s3[l] <= quot_neg[l] ? -{1'b0, quot[l]} : {1'b0, quot[l]};
			end
			tag_s3 <= quot_tag;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 4: coefficient products
	// ---------------------------------------------------------------------------------
	logic signed [KW-1:0] kr2;
	logic signed [KW-1:0] kb2;
	logic signed [PW-1:0] kr2_w;
	logic signed [PW-1:0] kb2_w;
	logic signed [PW-1:0] gcb_w;
	logic signed [PW-1:0] gcr_w;
	logic signed [PW-1:0] cb_w;
	logic signed [PW-1:0] cr_w;

	// 2 * (1024 - k) is negative for coefficients above 1024.
	assign kr2   = (KW'(ycrgb_pkg::COEFF_ONE) - {2'b00, red_coeff_q}) << 1;
	assign kb2   = (KW'(ycrgb_pkg::COEFF_ONE) - {2'b00, blue_coeff_q}) << 1;
	assign kr2_w = PW'(kr2);
	assign kb2_w = PW'(kb2);
	assign gcb_w = $signed(PW'(green_from_cb_q));
	assign gcr_w = $signed(PW'(green_from_cr_q));
	// An element of the packed array is unsigned, so the sign is restored before widening.
	assign cb_w  = PW'($signed(yc_s3[1]));
	assign cr_w  = PW'($signed(yc_s3[2]));

	logic signed [PW-1:0]  pr_s4;
	logic signed [PW-1:0]  pb_s4;
	logic signed [PW-1:0]  pgb_s4;
	logic signed [PW-1:0]  pgr_s4;
	logic signed [QW-1:0]  y_s4;
	ycrgb_pkg::pix_tag_t   tag_s4;

	always_ff @(posedge clk) begin
		if (en[ST_M1]) begin
			pr_s4  <= kr2_w * cr_w;
			pb_s4  <= kb2_w * cb_w;
			pgb_s4 <= gcb_w * cb_w;
			pgr_s4 <= gcr_w * cr_w;
			y_s4   <= yc_s3[0];
			tag_s4 <= tag_s3;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 5: combine the two green terms
	// ---------------------------------------------------------------------------------
	logic signed [UW-1:0]  pr_s5;
	logic signed [UW-1:0]  pb_s5;
	logic signed [UW-1:0]  pg_s5;
	logic signed [QW-1:0]  y_s5;
	ycrgb_pkg::pix_tag_t   tag_s5;

	always_ff @(posedge clk) begin
		if (en[ST_M2]) begin
			pr_s5  <= UW'(pr_s4);
			pb_s5  <= UW'(pb_s4);
			pg_s5  <= UW'(pgb_s4) + UW'(pgr_s4);
			y_s5   <= y_s4;
			tag_s5 <= tag_s4;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 6: divide the mixed terms by 1024, truncating toward zero
	// ---------------------------------------------------------------------------------
	logic signed [TW-1:0]  qr_s6;
	logic signed [TW-1:0]  qb_s6;
	logic signed [TW-1:0]  qg_s6;
	logic signed [QW-1:0]  y_s6;
	ycrgb_pkg::pix_tag_t   tag_s6;

	always_ff @(posedge clk) begin
		if (en[ST_M3]) begin
			qr_s6  <= trunc_div(pr_s5);
			qb_s6  <= trunc_div(pb_s5);
			qg_s6  <= trunc_div(pg_s5);
			y_s6   <= y_s5;
			tag_s6 <= tag_s5;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 7: add luma, clamp and narrow; RGB mode passes the shifted samples
	// ---------------------------------------------------------------------------------
	logic signed [XW-1:0] y_x;
	logic signed [XW-1:0] r_mix;
	logic signed [XW-1:0] g_mix;
	logic signed [XW-1:0] b_mix;

	assign y_x   = XW'(y_s6);
	assign r_mix = y_x + XW'(qr_s6);
	assign g_mix = y_x - XW'(qg_s6);
	assign b_mix = y_x + XW'(qb_s6);

	logic [OW-1:0] red_s7;
	logic [OW-1:0] green_s7;
	logic [OW-1:0] blue_s7;

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			if (tag_s6.ycbcr) begin
				red_s7   <= clamp_shift(r_mix);
				green_s7 <= clamp_shift(g_mix);
				blue_s7  <= clamp_shift(b_mix);
			end else begin
				red_s7   <= tag_s6.r;
				green_s7 <= tag_s6.g;
				blue_s7  <= tag_s6.b;
			end
		end
	end

	assign red_out   = red_s7;
	assign green_out = green_s7;
	assign blue_out  = blue_s7;

endmodule
